// File: hdl/text_console_cell_writer_defines.svh
// assertion macros for the text console cell writer
// used by the top level only, no other dependencies
`ifndef TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TCCW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("text console cell writer check failed");
`define TCCW_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("text console cell writer check failed");
`else
`define TCCW_ASSERT(lbl, prop)
`define TCCW_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hdl/tccw_pkg.sv
// shared constants, types and microcode table of the text console cell writer
// no dependencies
package tccw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int CELL_W  = $clog2(CELLS);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS + 1);
	localparam int TGT_W   = $clog2(COLUMNS + 1);

	localparam logic [2:0] KIND_PUT   = 3'd0;
	localparam logic [2:0] KIND_ERASE = 3'd1;
	localparam logic [2:0] KIND_CLEAR = 3'd2;
	localparam logic [2:0] KIND_PAD   = 3'd3;
	localparam logic [2:0] KIND_PRIME = 3'd4;
	localparam logic [2:0] KIND_READ  = 3'd5;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic       REG_FG = 1'b0;
	localparam logic       REG_BG = 1'b1;
	localparam logic [15:0] RESET_CELL = 16'h0720;

	typedef logic [4:0] step_t;

	localparam step_t S_IDLE       = 5'd0;
	localparam step_t S_PUT_GLYPH  = 5'd1;
	localparam step_t S_PUT_LF     = 5'd2;
	localparam step_t S_PUT_CR     = 5'd3;
	localparam step_t S_PUT_BS     = 5'd4;
	localparam step_t S_ERASE      = 5'd5;
	localparam step_t S_CLEAR      = 5'd6;
	localparam step_t S_CLEAR_FILL = 5'd7;
	localparam step_t S_PAD_TEST   = 5'd8;
	localparam step_t S_PAD_LOOP   = 5'd9;
	localparam step_t S_PRIME      = 5'd10;
	localparam step_t S_READ       = 5'd11;
	localparam step_t S_READ_LATCH = 5'd12;
	localparam step_t S_CHK_SCROLL = 5'd13;
	localparam step_t S_SCR_INIT   = 5'd14;
	localparam step_t S_SCR_COPY   = 5'd15;
	localparam step_t S_SCR_DRAIN  = 5'd16;
	localparam step_t S_SCR_FILL   = 5'd17;
	localparam step_t S_DONE       = 5'd18;
	localparam step_t S_INIT       = 5'd19;

	typedef enum logic [3:0] {
		A_NONE, A_GLYPH, A_LF, A_CR, A_BACK, A_ERASE, A_HOME, A_FILL,
		A_PRIME, A_READ, A_LATCH, A_SCR_INIT, A_COPY, A_FILL_INIT, A_INIT
	} act_t;

	typedef enum logic [2:0] {
		SQ_NEXT, SQ_JUMP, SQ_JUMP_IF, SQ_LOOP_IF, SQ_DISPATCH, SQ_WAIT_OUT
	} sq_t;

	typedef enum logic [2:0] {
		CD_NONE, CD_PTR_MORE, CD_PAD_NONE, CD_PAD_MORE, CD_NO_SCROLL
	} cd_t;

	typedef struct packed {
		act_t  act;
		sq_t   sq;
		cd_t   cd;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic ptr_more;
		logic pad_none;
		logic pad_more;
		logic no_scroll;
	} cond_in_t;

	typedef struct packed {
		act_t act;
		logic take;
		logic out_load;
	} ctl_t;

	function automatic ctrl_word_t ucode(input step_t pc);
		ctrl_word_t w;
		case (pc)
			S_IDLE:       w = '{A_NONE,      SQ_DISPATCH, CD_NONE,      S_IDLE};
			S_PUT_GLYPH:  w = '{A_GLYPH,     SQ_JUMP,     CD_NONE,      S_CHK_SCROLL};
			S_PUT_LF:     w = '{A_LF,        SQ_JUMP,     CD_NONE,      S_CHK_SCROLL};
			S_PUT_CR:     w = '{A_CR,        SQ_JUMP,     CD_NONE,      S_DONE};
			S_PUT_BS:     w = '{A_BACK,      SQ_JUMP,     CD_NONE,      S_DONE};
			S_ERASE:      w = '{A_ERASE,     SQ_JUMP,     CD_NONE,      S_DONE};
			S_CLEAR:      w = '{A_HOME,      SQ_NEXT,     CD_NONE,      S_IDLE};
			S_CLEAR_FILL: w = '{A_FILL,      SQ_LOOP_IF,  CD_PTR_MORE,  S_DONE};
			S_PAD_TEST:   w = '{A_NONE,      SQ_JUMP_IF,  CD_PAD_NONE,  S_DONE};
			S_PAD_LOOP:   w = '{A_GLYPH,     SQ_LOOP_IF,  CD_PAD_MORE,  S_CHK_SCROLL};
			S_PRIME:      w = '{A_PRIME,     SQ_JUMP,     CD_NONE,      S_DONE};
			S_READ:       w = '{A_READ,      SQ_NEXT,     CD_NONE,      S_IDLE};
			S_READ_LATCH: w = '{A_LATCH,     SQ_JUMP,     CD_NONE,      S_DONE};
			S_CHK_SCROLL: w = '{A_NONE,      SQ_JUMP_IF,  CD_NO_SCROLL, S_DONE};
			S_SCR_INIT:   w = '{A_SCR_INIT,  SQ_NEXT,     CD_NONE,      S_IDLE};
			S_SCR_COPY:   w = '{A_COPY,      SQ_LOOP_IF,  CD_PTR_MORE,  S_SCR_DRAIN};
			S_SCR_DRAIN:  w = '{A_FILL_INIT, SQ_NEXT,     CD_NONE,      S_IDLE};
			S_SCR_FILL:   w = '{A_FILL,      SQ_LOOP_IF,  CD_PTR_MORE,  S_DONE};
			S_DONE:       w = '{A_NONE,      SQ_WAIT_OUT, CD_NONE,      S_IDLE};
			S_INIT:       w = '{A_INIT,      SQ_LOOP_IF,  CD_PTR_MORE,  S_IDLE};
			default:      w = '{A_NONE,      SQ_JUMP,     CD_NONE,      S_IDLE};
		endcase
		return w;
	endfunction

	function automatic step_t dispatch(input logic [2:0] kind, input logic [7:0] ch);
		step_t s;
		case (kind)
			KIND_PUT: begin
				if (ch == CH_LF)
					s = S_PUT_LF;
				else if (ch == CH_CR)
					s = S_PUT_CR;
				else if (ch == CH_BS)
					s = S_PUT_BS;
				else
					s = S_PUT_GLYPH;
			end
			KIND_ERASE: s = S_ERASE;
			KIND_CLEAR: s = S_CLEAR;
			KIND_PAD:   s = S_PAD_TEST;
			KIND_PRIME: s = S_PRIME;
			KIND_READ:  s = S_READ;
			default:    s = S_DONE;
		endcase
		return s;
	endfunction

endpackage

// File: hdl/tccw_seq.sv
// microcode sequencer: step counter, control word table and jump logic
// depends on tccw_pkg
module tccw_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  tccw_pkg::cond_in_t cin,
	input  tccw_pkg::step_t    entry,
	output tccw_pkg::ctl_t     ctl
);
	import tccw_pkg::*;

	step_t      pc_q;
	step_t      pc_nxt;
	ctrl_word_t cw;
	logic       cond;

	assign cw = ucode(pc_q);

	always_comb begin
		case (cw.cd)
			CD_PTR_MORE:  cond = cin.ptr_more;
			CD_PAD_NONE:  cond = cin.pad_none;
			CD_PAD_MORE:  cond = cin.pad_more;
			CD_NO_SCROLL: cond = cin.no_scroll;
			default:      cond = 1'b0;
		endcase
	end

	always_comb begin
		case (cw.sq)
			SQ_NEXT:     pc_nxt = step_t'(pc_q + 5'd1);
			SQ_JUMP:     pc_nxt = cw.target;
			SQ_JUMP_IF:  pc_nxt = cond ? cw.target : step_t'(pc_q + 5'd1);
			SQ_LOOP_IF:  pc_nxt = cond ? pc_q : cw.target;
			SQ_DISPATCH: pc_nxt = cin.in_valid ? entry : pc_q;
			SQ_WAIT_OUT: pc_nxt = cin.out_free ? cw.target : pc_q;
			default:     pc_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= S_INIT;
		else
			pc_q <= pc_nxt;
	end

	assign ctl.act      = cw.act;
	assign ctl.take     = (cw.sq == SQ_DISPATCH);
	assign ctl.out_load = (cw.sq == SQ_WAIT_OUT) && cin.out_free;

endmodule

// File: hdl/text_console_cell_writer.sv
// text console cell writer: cursor, colour registers and 80x25 cell store
// pad, scroll and clear write the cells one at a time (single memory port)
// one word in flight; the next word is taken only once the result is registered
// after reset a clearing pass fills all 2000 cells of the store, no word taken meanwhile
// depends on tccw_pkg, tccw_seq and text_console_cell_writer_defines.svh
`include "text_console_cell_writer_defines.svh"

module text_console_cell_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_code, target_column, cell_address
	input  logic [2:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // cursor_row, cursor_column, cursor_position, cell_data
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import tccw_pkg::*;

	logic [15:0] mem [CELLS];
	logic [15:0] rdata_q;

	ctl_t     ctl;
	cond_in_t cin;
	step_t    entry;

	logic [3:0]        fg_q, bg_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [CELL_W-1:0] ptr_q;
	logic [7:0]        ch_q;
	logic [TGT_W-1:0]  tgt_q;
	logic [10:0]       addr_q;
	logic [15:0]       data_q;
	logic              cp_vld_s1;
	logic [CELL_W-1:0] cp_addr_s1;
	logic              m_tvalid_q;
	logic [39:0]       m_tdata_q;

	logic [7:0]        attr;
	logic [15:0]       blank;
	logic [CELL_W-1:0] cur_addr;
	logic [CELL_W-1:0] rd_addr;
	logic              step_we;
	logic              we;
	logic [CELL_W-1:0] wa;
	logic [15:0]       wd;
	logic              fire;
	logic              addr_ok;
	logic [TGT_W-1:0]  col_ext;
	logic [TGT_W-1:0]  tgt_in;

	tccw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cin    (cin),
		.entry  (entry),
		.ctl    (ctl)
	);

	assign attr     = {bg_q, fg_q};
	assign blank    = {attr, CH_SPACE};
	assign cur_addr = CELL_W'(CELL_W'(row_q) * CELL_W'(COLUMNS)) + CELL_W'(col_q);
	assign col_ext  = TGT_W'(col_q);
	assign addr_ok  = (32'(addr_q) < CELLS);
	assign tgt_in   = (32'(s_tdata[14:8]) > COLUMNS) ? TGT_W'(COLUMNS) : TGT_W'(s_tdata[14:8]);

	assign s_tready = ctl.take;
	assign fire     = s_tvalid && ctl.take;
	assign entry    = dispatch(s_tuser, s_tdata[7:0]);

	assign cin.in_valid  = s_tvalid;
	assign cin.out_free  = !m_tvalid_q || m_tready;
	assign cin.ptr_more  = (ptr_q != CELL_W'(CELLS - 1));
	assign cin.pad_none  = (col_ext >= tgt_q);
	assign cin.pad_more  = (TGT_W'(col_ext + 1'b1) != tgt_q);
	assign cin.no_scroll = (row_q != ROW_W'(ROWS));

	assign rd_addr = (ctl.act == A_COPY) ? ptr_q : CELL_W'(addr_q);

	// step writes, one per control word
	always_comb begin
		step_we = 1'b0;
		wa      = cur_addr;
		wd      = blank;
		case (ctl.act)
			A_GLYPH: begin
				step_we = 1'b1;
				wd      = {attr, ch_q};
			end
			A_ERASE: begin
				step_we = (col_q != '0);
				wa      = CELL_W'(cur_addr - 1'b1);
			end
			A_PRIME: step_we = 1'b1;
			A_FILL: begin
				step_we = 1'b1;
				wa      = ptr_q;
			end
			A_INIT: begin
				step_we = 1'b1;
				wa      = ptr_q;
				wd      = RESET_CELL;
			end
			default: step_we = 1'b0;
		endcase
	end

	// delayed copy write of a scroll has the port
	always_comb begin
		if (cp_vld_s1)
			we = 1'b1;
		else
			we = step_we;
	end

	logic [CELL_W-1:0] wr_addr;
	logic [15:0]       wr_data;
	assign wr_addr = cp_vld_s1 ? cp_addr_s1 : wa;
	assign wr_data = cp_vld_s1 ? rdata_q : wd;

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 4'd7;
			bg_q <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FG:  fg_q <= cfg_data;
				REG_BG:  bg_q <= cfg_data;
				default: fg_q <= fg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			ptr_q     <= '0;
			cp_vld_s1 <= 1'b0;
		end else begin
			cp_vld_s1 <= (ctl.act == A_COPY);
			case (ctl.act)
				A_GLYPH: begin
					if (col_q == COL_W'(COLUMNS - 1)) begin
						col_q <= '0;
						row_q <= ROW_W'(row_q + 1'b1);
					end else begin
						col_q <= COL_W'(col_q + 1'b1);
					end
				end
				A_LF: begin
					col_q <= '0;
					row_q <= ROW_W'(row_q + 1'b1);
				end
				A_CR: col_q <= '0;
				A_BACK, A_ERASE: begin
					if (col_q != '0)
						col_q <= COL_W'(col_q - 1'b1);
				end
				A_HOME: begin
					row_q <= '0;
					col_q <= '0;
					ptr_q <= '0;
				end
				A_FILL, A_INIT, A_COPY: ptr_q <= CELL_W'(ptr_q + 1'b1);
				A_SCR_INIT: begin
					ptr_q <= CELL_W'(COLUMNS);
					row_q <= ROW_W'(ROWS - 1);
				end
				A_FILL_INIT: ptr_q <= CELL_W'(CELLS - COLUMNS);
				default: ptr_q <= ptr_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.act == A_COPY)
			cp_addr_s1 <= CELL_W'(ptr_q - CELL_W'(COLUMNS));
		if (fire) begin
			ch_q   <= s_tdata[7:0];
			tgt_q  <= tgt_in;
			addr_q <= s_tdata[25:15];
			data_q <= '0;
		end else if (ctl.act == A_LATCH) begin
			data_q <= addr_ok ? rdata_q : 16'h0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (ctl.out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load)
			m_tdata_q <= {1'b0, data_q, 11'(cur_addr), 7'(col_q), 5'(row_q)};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`TCCW_ASSERT(a_cursor_range, ctl.out_load |-> (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
	`TCCW_ASSERT(a_one_word, s_tvalid && s_tready |=> !s_tready)
	`TCCW_ASSERT_ALWAYS(a_write_port, !(cp_vld_s1 && step_we))

endmodule

// File: tb/sv/tb.sv
// testbench for the text console cell writer: directed table, then random phases
// cursor reports: checked against a cell store and cursor model, or typed wants
// depends on tccw_pkg and text_console_cell_writer
`timescale 1ns / 100ps

module tb;
	import tccw_pkg::*;

	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;
	localparam int DIRECTED_N = 24;
	localparam int PHASE_ITEMS = 92;

	// row in the lowest bits, as on m_tdata
	typedef struct packed {
		logic [15:0] data;
		logic [10:0] pos;
		logic [6:0]  col;
		logic [4:0]  row;
	} cursor_report_t;

	typedef struct packed {
		logic [2:0]     kind;
		logic [7:0]     ch;
		logic [6:0]     tgt;
		logic [10:0]    addr;
		logic           typed;
		cursor_report_t want;
	} console_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // char_code, target_column, cell_address
	logic [2:0]  s_tuser;   // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // cursor_row, cursor_column, cursor_position, cell_data
	logic        cfg_we;
	logic        cfg_index;
	logic [3:0]  cfg_data;

	text_console_cell_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [15:0] screen [0:CELLS-1];
	int unsigned cur_row;
	int unsigned cur_col;
	logic [3:0] fg_color;
	logic [3:0] bg_color;

	cursor_report_t pending_reports [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	console_word_t directed_rows [0:DIRECTED_N-1] = '{
		'{KIND_READ,  8'h00, 7'd0,   11'd0,    1'b1, '{16'h0720, 11'd0, 7'd0, 5'd0}},
		'{KIND_READ,  8'h00, 7'd0,   11'd1999, 1'b1, '{16'h0720, 11'd0, 7'd0, 5'd0}},
		'{KIND_READ,  8'hFF, 7'd127, 11'd2000, 1'b1, '{16'h0000, 11'd0, 7'd0, 5'd0}},
		'{KIND_READ,  8'h00, 7'd0,   11'd2047, 1'b1, '{16'h0000, 11'd0, 7'd0, 5'd0}},
		'{KIND_PUT,   8'h41, 7'd0,   11'd0,    1'b1, '{16'h0000, 11'd1, 7'd1, 5'd0}},
		'{KIND_READ,  8'h00, 7'd0,   11'd0,    1'b1, '{16'h0741, 11'd1, 7'd1, 5'd0}},
		'{KIND_PUT,   8'h00, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_PUT,   8'hFF, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_PUT,   CH_BS, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_ERASE, 8'h00, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_PUT,   CH_CR, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_PUT,   CH_BS, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_ERASE, 8'h00, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_PAD,   CH_LF, 7'd79,  11'd0,    1'b0, '0},
		'{KIND_PUT,   8'h5A, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_PUT,   CH_LF, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_PAD,   CH_BS, 7'd127, 11'd0,    1'b0, '0},
		'{KIND_PAD,   8'h2A, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_PRIME, 8'h00, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_READ,  8'h00, 7'd0,   11'd79,   1'b0, '0},
		'{KIND_SPARE_A, 8'h11, 7'd5, 11'd5,    1'b0, '0},
		'{KIND_SPARE_B, 8'hEE, 7'd122, 11'd2042, 1'b0, '0},
		'{KIND_CLEAR, 8'h00, 7'd0,   11'd0,    1'b0, '0},
		'{KIND_READ,  8'h00, 7'd0,   11'd0,    1'b0, '0}
	};

	function automatic logic [15:0] blank_cell();
		return {bg_color, fg_color, CH_SPACE};
	endfunction

	function automatic void settle_rows();
		if (cur_row >= ROWS) begin
			for (int i = 0; i < CELLS - COLUMNS; i++)
				screen[i] = screen[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen[i] = blank_cell();
			cur_row = ROWS - 1;
		end
	endfunction

	function automatic void put_glyph(input logic [7:0] ch);
		screen[cur_row * COLUMNS + cur_col] = {bg_color, fg_color, ch};
		cur_col++;
		if (cur_col >= COLUMNS) begin
			cur_col = 0;
			cur_row++;
		end
		settle_rows();
	endfunction

	function automatic cursor_report_t console_apply(input logic [2:0] kind,
			input logic [7:0] ch, input logic [6:0] tgt, input logic [10:0] addr);
		cursor_report_t r;
		int unsigned limit;
		int unsigned n;
		int unsigned lin;
		r.data = '0;
		case (kind)
			KIND_PUT: begin
				if (ch == CH_LF) begin
					cur_col = 0;
					cur_row++;
					settle_rows();
				end else if (ch == CH_CR) begin
					cur_col = 0;
				end else if (ch == CH_BS) begin
					if (cur_col > 0)
						cur_col--;
				end else begin
					put_glyph(ch);
				end
			end
			KIND_ERASE: begin
				if (cur_col > 0) begin
					cur_col--;
					screen[cur_row * COLUMNS + cur_col] = blank_cell();
				end
			end
			KIND_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen[i] = blank_cell();
				cur_row = 0;
				cur_col = 0;
			end
			KIND_PAD: begin
				limit = (tgt > COLUMNS) ? COLUMNS : tgt;
				if (cur_col < limit) begin
					n = limit - cur_col;
					repeat (n) put_glyph(ch);
				end
			end
			KIND_PRIME: screen[cur_row * COLUMNS + cur_col] = blank_cell();
			KIND_READ: begin
				if (addr < CELLS)
					r.data = screen[addr];
			end
			default: ;
		endcase
		lin = cur_row * COLUMNS + cur_col;
		r.row = cur_row[4:0];
		r.col = cur_col[6:0];
		r.pos = lin[10:0];
		return r;
	endfunction

	function automatic console_word_t pick_random_word();
		console_word_t w;
		int unsigned roll;
		int unsigned where;
		w.kind = KIND_PUT;
		w.ch = 8'($urandom_range(0, 255));
		w.tgt = 7'($urandom_range(0, 127));
		w.addr = 11'($urandom_range(0, 2047));
		w.typed = 1'b0;
		w.want = '0;
		roll = $urandom_range(0, 999);
		if (roll < 450) begin
		end else if (roll < 570) begin
			w.ch = CH_LF;
		end else if (roll < 590) begin
			w.ch = CH_CR;
		end else if (roll < 620) begin
			w.ch = CH_BS;
		end else if (roll < 690) begin
			w.kind = KIND_ERASE;
		end else if (roll < 695) begin
			w.kind = KIND_CLEAR;
		end else if (roll < 780) begin
			w.kind = KIND_PAD;
			if ($urandom_range(0, 4) != 0)
				w.tgt = 7'($urandom_range(0, COLUMNS - 1));
		end else if (roll < 820) begin
			w.kind = KIND_PRIME;
		end else if (roll < 980) begin
			w.kind = KIND_READ;
			where = $urandom_range(0, 9);
			if (where < 6)
				w.addr = 11'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
			else if (where < 9)
				w.addr = 11'($urandom_range(0, CELLS - 1));
		end else begin
			w.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_word(input console_word_t w);
		cursor_report_t pred;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= w.kind;
		s_tdata <= {6'd0, w.addr, w.tgt, w.ch};
		do @(posedge clk); while (!s_tready);
		pred = console_apply(w.kind, w.ch, w.tgt, w.addr);
		pending_reports.push_back(w.typed ? w.want : pred);
		@(negedge clk);
	endtask

	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_colors(input logic [3:0] fg, input logic [3:0] bg);
		cfg_we <= 1'b1;
		cfg_index <= REG_FG;
		cfg_data <= fg;
		@(negedge clk);
		cfg_index <= REG_BG;
		cfg_data <= bg;
		@(negedge clk);
		cfg_we <= 1'b0;
		fg_color = fg;
		bg_color = bg;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cursor_report_t got;
		cursor_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[38:0];
			if (pending_reports.size() == 0) begin
				report_mismatch("word with nothing expected", int'(got.pos), 0);
			end else begin
				want = pending_reports.pop_front();
				if (got.row !== want.row)
					report_mismatch("cursor_row", int'(got.row), int'(want.row));
				if (got.col !== want.col)
					report_mismatch("cursor_column", int'(got.col), int'(want.col));
				if (got.pos !== want.pos)
					report_mismatch("cursor_position", int'(got.pos), int'(want.pos));
				if (got.data !== want.data)
					report_mismatch("cell_data", int'(got.data), int'(want.data));
			end
		end
	end

	initial begin
		#40_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [3:0] fg;
		logic [3:0] bg;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = REG_FG;
		cfg_data = '0;
		fg_color = 4'd7;
		bg_color = 4'd0;
		for (int i = 0; i < CELLS; i++)
			screen[i] = RESET_CELL;
		cur_row = 0;
		cur_col = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		for (int k = 0; k < DIRECTED_N; k++)
			send_word(directed_rows[k]);
		drain_reports();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin fg = 4'd0;  bg = 4'd0;  end
				1: begin fg = 4'd15; bg = 4'd15; end
				2: begin fg = 4'd15; bg = 4'd0;  end
				3: begin fg = 4'd0;  bg = 4'd15; end
				default: begin
					fg = 4'($urandom_range(0, 15));
					bg = 4'($urandom_range(0, 15));
				end
			endcase
			write_colors(fg, bg);
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 50; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 50; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			repeat (PHASE_ITEMS) send_word(pick_random_word());
			drain_reports();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tccw_pkg.sv
hdl/tccw_seq.sv
hdl/text_console_cell_writer.sv
tb/sv/tb.sv
